// ===== rtl/trp_pkg.sv =====
// Shared constants, types and helper functions for the triangle transform block.
package trp_pkg;

	localparam int SCREEN_WIDTH_DEF  = 640;
	localparam int SCREEN_HEIGHT_DEF = 480;
	localparam int SINE_DEPTH_DEF    = 256;

	localparam logic [2:0] REG_CAM_X   = 3'd0;
	localparam logic [2:0] REG_CAM_Y   = 3'd1;
	localparam logic [2:0] REG_CAM_Z   = 3'd2;
	localparam logic [2:0] REG_ANGLE_X = 3'd3;
	localparam logic [2:0] REG_ANGLE_Y = 3'd4;
	localparam logic [2:0] REG_ANGLE_Z = 3'd5;
	localparam logic [2:0] REG_FOCAL   = 3'd6;

	localparam logic [15:0] FOCAL_RESET = 16'd256;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam int DIFF_W  = 33;
	localparam int COORD_W = 35;
	localparam int PROD_W  = 51;
	localparam int SUM_W   = 52;
	localparam int HALF_W  = 14;
	localparam int HF_W    = 30;
	localparam int TOP_W   = 64;
	localparam int QUOT_W  = 16;

	localparam int LANE_LAT = 11 + QUOT_W;
	localparam int TRP_LAT  = LANE_LAT + 1;

	localparam logic signed [SUM_W-1:0] COORD_LIM = 52'sd17179869183;

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
		logic zero;
	} trp_flags_t;

	typedef struct packed {
		logic       vis;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} trp_side_t;

	function automatic logic [14:0] quarter_entry(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		longint r;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 110;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 156;
		sum  = sum + $signed(term);
		if (sum < 0)
			sum = 0;
		r = (sum + 16384) >>> 15;
		if (r > 32767)
			r = 32767;
		return r[14:0];
	endfunction

	function automatic logic signed [COORD_W-1:0] hold_shift(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] t;
		t = s >>> 15;
		if (t > COORD_LIM)
			t = COORD_LIM;
		else if (t < -COORD_LIM)
			t = -COORD_LIM;
		return t[COORD_W-1:0];
	endfunction

	function automatic logic signed [15:0] sat_quot(input logic [QUOT_W-1:0] q, input logic neg,
			input logic ovf, input logic zero);
		logic signed [QUOT_W:0] v;
		v = $signed({1'b0, q});
		if (zero)
			return 16'sd0;
		if (ovf)
			return neg ? -16'sd32768 : 16'sd32767;
		if (neg) begin
			v = -v;
			if (v < -17'sd32768)
				return -16'sd32768;
			return v[15:0];
		end
		if (v > 17'sd32767)
			return 16'sd32767;
		return v[15:0];
	endfunction

endpackage

// ===== rtl/trp_trig.sv =====
// Quarter-wave sine table with sine and cosine lookup for one angle.
module trp_trig #(
	parameter int SINE_TABLE_DEPTH = trp_pkg::SINE_DEPTH_DEF
) (
	input  logic [15:0]        angle,
	output logic signed [15:0] sin_v,
	output logic signed [15:0] cos_v
);

	localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW = IW + 14;

	logic [14:0] quarter [0:SINE_TABLE_DEPTH];
	logic [15:0] cos_angle;

	for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_tab
		localparam longint unsigned XQ = (trp_pkg::HALF_PI_Q30 * i) / SINE_TABLE_DEPTH;
		assign quarter[i] = trp_pkg::quarter_entry(XQ);
	end

	function automatic logic signed [15:0] lookup(input logic [15:0] a);
		logic [PW-1:0] prod;
		logic [IW-1:0] idx;
		logic [14:0]   mag;
		prod = PW'(a[13:0]) * PW'(SINE_TABLE_DEPTH);
		idx  = prod[PW-1:14];
		mag  = a[14] ? quarter[IW'(SINE_TABLE_DEPTH) - idx] : quarter[idx];
		return a[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	assign cos_angle = angle + 16'd16384;

	always_comb begin
		sin_v = lookup(angle);
		cos_v = lookup(cos_angle);
	end

endmodule

// ===== rtl/trp_div.sv =====
// Pipelined restoring divider giving a short unsigned quotient, one bit per stage.
module trp_div (
	input  logic                                 clk,
	input  logic [trp_pkg::TOP_W-1:0]            num,
	input  logic [trp_pkg::TOP_W-1:0]            den,
	output logic [trp_pkg::QUOT_W-1:0]           quot
);

	localparam int NW = trp_pkg::TOP_W;
	localparam int QW = trp_pkg::QUOT_W;

	logic [NW-1:0] rem_s  [0:QW];
	logic [NW-1:0] den_s  [0:QW];
	logic [QW-1:0] quot_s [0:QW];

	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign quot_s[0] = '0;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [NW:0] diff;
		assign diff = {1'b0, rem_s[k]} - {1'b0, den_s[k] << (QW - 1 - k)};
		always_ff @(posedge clk) begin
			rem_s[k+1]  <= diff[NW] ? rem_s[k] : diff[NW-1:0];
			den_s[k+1]  <= den_s[k];
			quot_s[k+1] <= {quot_s[k][QW-2:0], ~diff[NW]};
		end
	end

	assign quot = quot_s[QW];

endmodule

// ===== rtl/trp_lane.sv =====
// One vertex lane: translate, three rotations, projection and saturation.
module trp_lane #(
	parameter int HALF_X = trp_pkg::SCREEN_WIDTH_DEF / 2,
	parameter int HALF_Y = trp_pkg::SCREEN_HEIGHT_DEF / 2
) (
	input  logic                                 clk,
	input  logic signed [31:0]                   vx,
	input  logic signed [31:0]                   vy,
	input  logic signed [31:0]                   vz,
	input  logic signed [31:0]                   cam_x,
	input  logic signed [31:0]                   cam_y,
	input  logic signed [31:0]                   cam_z,
	input  logic signed [15:0]                   sin_x,
	input  logic signed [15:0]                   cos_x,
	input  logic signed [15:0]                   sin_y,
	input  logic signed [15:0]                   cos_y,
	input  logic signed [15:0]                   sin_z,
	input  logic signed [15:0]                   cos_z,
	input  logic signed [trp_pkg::HF_W-1:0]      hf_x,
	input  logic signed [trp_pkg::HF_W-1:0]      hf_y,
	output logic signed [15:0]                   px,
	output logic signed [15:0]                   py,
	output logic                                 zero
);

	localparam int DW = trp_pkg::DIFF_W;
	localparam int CW = trp_pkg::COORD_W;
	localparam int PW = trp_pkg::PROD_W;
	localparam int SW = trp_pkg::SUM_W;
	localparam int TW = trp_pkg::TOP_W;
	localparam int QS = trp_pkg::QUOT_W;
	localparam logic signed [trp_pkg::HALF_W-1:0] HX = trp_pkg::HALF_W'(HALF_X);
	localparam logic signed [trp_pkg::HALF_W-1:0] HY = trp_pkg::HALF_W'(HALF_Y);

	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [PW-1:0] pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [DW-1:0] dz_s2;
	logic signed [CW-1:0] x1_s3, y1_s3;
	logic signed [DW-1:0] dz_s3;
	logic signed [PW-1:0] pa_s4, pb_s4, pc_s4, pd_s4;
	logic signed [CW-1:0] y1_s4;
	logic signed [CW-1:0] x2_s5, z2_s5, y1_s5;
	logic signed [PW-1:0] pa_s6, pb_s6, pc_s6, pd_s6;
	logic signed [CW-1:0] x2_s6;
	logic signed [CW-1:0] y3_s7, z3_s7, x2_s7;
	logic signed [64:0]   fz_s8, fy_s8;
	logic signed [48:0]   hrx_s8, hry_s8;
	logic signed [CW-1:0] x2_s8;
	logic signed [TW-1:0] top_x_s9, top_y_s9;
	logic signed [CW-1:0] x2_s9;
	logic [TW-1:0]        mag_x_s10, mag_y_s10, mag_d_s10;
	trp_pkg::trp_flags_t  flags_s10;
	trp_pkg::trp_flags_t  flags_d [0:QS-1];
	logic [QS-1:0]        quot_x, quot_y;
	logic signed [42:0]   den_w;
	logic [TW-1:0]        mag_x_w, mag_y_w, mag_d_w;

	always_ff @(posedge clk) begin
		dx_s1 <= DW'(vx) - DW'(cam_x);
		dy_s1 <= DW'(vy) - DW'(cam_y);
		dz_s1 <= DW'(vz) - DW'(cam_z);

		pa_s2 <= cos_z * dx_s1;
		pb_s2 <= sin_z * dy_s1;
		pc_s2 <= cos_z * dy_s1;
		pd_s2 <= sin_z * dx_s1;
		dz_s2 <= dz_s1;

		x1_s3 <= trp_pkg::hold_shift(SW'(pa_s2) + SW'(pb_s2));
		y1_s3 <= trp_pkg::hold_shift(SW'(pc_s2) - SW'(pd_s2));
		dz_s3 <= dz_s2;

		pa_s4 <= cos_y * x1_s3;
		pb_s4 <= sin_y * dz_s3;
		pc_s4 <= sin_y * x1_s3;
		pd_s4 <= cos_y * dz_s3;
		y1_s4 <= y1_s3;

		x2_s5 <= trp_pkg::hold_shift(SW'(pa_s4) - SW'(pb_s4));
		z2_s5 <= trp_pkg::hold_shift(SW'(pc_s4) + SW'(pd_s4));
		y1_s5 <= y1_s4;

		pa_s6 <= cos_x * y1_s5;
		pb_s6 <= sin_x * z2_s5;
		pc_s6 <= cos_x * z2_s5;
		pd_s6 <= sin_x * y1_s5;
		x2_s6 <= x2_s5;

		y3_s7 <= trp_pkg::hold_shift(SW'(pa_s6) + SW'(pb_s6));
		z3_s7 <= trp_pkg::hold_shift(SW'(pc_s6) - SW'(pd_s6));
		x2_s7 <= x2_s6;

		fz_s8  <= hf_x * z3_s7;
		fy_s8  <= hf_y * y3_s7;
		hrx_s8 <= HX * x2_s7;
		hry_s8 <= HY * x2_s7;
		x2_s8  <= x2_s7;

		top_x_s9 <= $signed(fz_s8[TW-1:0]) + (TW'(hrx_s8) <<< 8);
		top_y_s9 <= $signed(fy_s8[TW-1:0]) + (TW'(hry_s8) <<< 8);
		x2_s9    <= x2_s8;

		mag_x_s10 <= mag_x_w;
		mag_y_s10 <= mag_y_w;
		mag_d_s10 <= mag_d_w;
		flags_s10 <= '{neg_x: top_x_s9[TW-1] ^ x2_s9[CW-1],
		               neg_y: top_y_s9[TW-1] ^ x2_s9[CW-1],
		               ovf_x: mag_x_w >= (mag_d_w << QS),
		               ovf_y: mag_y_w >= (mag_d_w << QS),
		               zero:  x2_s9 == '0};
	end

	assign den_w   = 43'(x2_s9) <<< 8;
	assign mag_x_w = top_x_s9[TW-1] ? TW'(-top_x_s9) : TW'(top_x_s9);
	assign mag_y_w = top_y_s9[TW-1] ? TW'(-top_y_s9) : TW'(top_y_s9);
	assign mag_d_w = den_w[42] ? TW'(-den_w) : TW'(den_w);

	trp_div u_div_x (
		.clk  (clk),
		.num  (mag_x_s10),
		.den  (mag_d_s10),
		.quot (quot_x)
	);

	trp_div u_div_y (
		.clk  (clk),
		.num  (mag_y_s10),
		.den  (mag_d_s10),
		.quot (quot_y)
	);

	always_ff @(posedge clk) begin
		flags_d[0] <= flags_s10;
		for (int k = 1; k < QS; k++)
			flags_d[k] <= flags_d[k-1];
		px   <= trp_pkg::sat_quot(quot_x, flags_d[QS-1].neg_x, flags_d[QS-1].ovf_x,
		                          flags_d[QS-1].zero);
		py   <= trp_pkg::sat_quot(quot_y, flags_d[QS-1].neg_y, flags_d[QS-1].ovf_y,
		                          flags_d[QS-1].zero);
		zero <= flags_d[QS-1].zero;
	end

endmodule

// ===== rtl/triangle_rotate_project.sv =====
// Top level: configuration registers, three vertex lanes and the merging stage.
// Throughput: one triangle per cycle; busy never rises, all three lanes run in step.
// Latency is set by the rotation pipeline and the 16-stage quotient unit in each lane.
// Reset clears the configuration registers and the valid chain; results are never held back.
module triangle_rotate_project #(
	parameter int SCREEN_WIDTH     = trp_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT    = trp_pkg::SCREEN_HEIGHT_DEF,
	parameter int SINE_TABLE_DEPTH = trp_pkg::SINE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic signed [31:0] v0_x,
	input  logic signed [31:0] v0_y,
	input  logic signed [31:0] v0_z,
	input  logic signed [31:0] v1_x,
	input  logic signed [31:0] v1_y,
	input  logic signed [31:0] v1_z,
	input  logic signed [31:0] v2_x,
	input  logic signed [31:0] v2_y,
	input  logic signed [31:0] v2_z,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output logic               done,
	output logic signed [15:0] p0_x,
	output logic signed [15:0] p0_y,
	output logic signed [15:0] p1_x,
	output logic signed [15:0] p1_y,
	output logic signed [15:0] p2_x,
	output logic signed [15:0] p2_y,
	output logic [7:0]         red_out,
	output logic [7:0]         green_out,
	output logic [7:0]         blue_out,
	output logic               visible,
	output logic               depth_zero
);

	localparam int LAT = trp_pkg::TRP_LAT;
	localparam int HFW = trp_pkg::HF_W;
	localparam logic [trp_pkg::HALF_W-1:0] HALF_X = trp_pkg::HALF_W'(SCREEN_WIDTH / 2);
	localparam logic [trp_pkg::HALF_W-1:0] HALF_Y = trp_pkg::HALF_W'(SCREEN_HEIGHT / 2);

	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic [15:0]        angle_x_q, angle_y_q, angle_z_q, focal_q;
	logic signed [15:0] sin_x_w, cos_x_w, sin_y_w, cos_y_w, sin_z_w, cos_z_w;
	logic signed [15:0] sin_x_q, cos_x_q, sin_y_q, cos_y_q, sin_z_q, cos_z_q;
	logic signed [HFW-1:0] hf_x_q, hf_y_q;
	logic               accept;
	logic [LAT-1:0]     vld_q;
	trp_pkg::trp_side_t side_q [0:LAT-2];
	logic signed [31:0] lane_vx [3];
	logic signed [31:0] lane_vy [3];
	logic signed [31:0] lane_vz [3];
	logic signed [15:0] lane_px [3];
	logic signed [15:0] lane_py [3];
	logic [2:0]         lane_zero;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q   <= '0;
			cam_y_q   <= '0;
			cam_z_q   <= '0;
			angle_x_q <= '0;
			angle_y_q <= '0;
			angle_z_q <= '0;
			focal_q   <= trp_pkg::FOCAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				trp_pkg::REG_CAM_X:   cam_x_q   <= cfg_data;
				trp_pkg::REG_CAM_Y:   cam_y_q   <= cfg_data;
				trp_pkg::REG_CAM_Z:   cam_z_q   <= cfg_data;
				trp_pkg::REG_ANGLE_X: angle_x_q <= cfg_data[15:0];
				trp_pkg::REG_ANGLE_Y: angle_y_q <= cfg_data[15:0];
				trp_pkg::REG_ANGLE_Z: angle_z_q <= cfg_data[15:0];
				trp_pkg::REG_FOCAL:   focal_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	trp_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_x (
		.angle (angle_x_q), .sin_v (sin_x_w), .cos_v (cos_x_w));
	trp_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_y (
		.angle (angle_y_q), .sin_v (sin_y_w), .cos_v (cos_y_w));
	trp_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_z (
		.angle (angle_z_q), .sin_v (sin_z_w), .cos_v (cos_z_w));

	always_ff @(posedge clk) begin
		sin_x_q <= sin_x_w;
		cos_x_q <= cos_x_w;
		sin_y_q <= sin_y_w;
		cos_y_q <= cos_y_w;
		sin_z_q <= sin_z_w;
		cos_z_q <= cos_z_w;
		hf_x_q  <= $signed(HFW'(HALF_X * focal_q));
		hf_y_q  <= $signed(HFW'(HALF_Y * focal_q));
	end

	assign lane_vx = '{v0_x, v1_x, v2_x};
	assign lane_vy = '{v0_y, v1_y, v2_y};
	assign lane_vz = '{v0_z, v1_z, v2_z};

	for (genvar l = 0; l < 3; l++) begin : g_lane
		trp_lane #(.HALF_X(SCREEN_WIDTH / 2), .HALF_Y(SCREEN_HEIGHT / 2)) u_lane (
			.clk   (clk),
			.vx    (lane_vx[l]),
			.vy    (lane_vy[l]),
			.vz    (lane_vz[l]),
			.cam_x (cam_x_q),
			.cam_y (cam_y_q),
			.cam_z (cam_z_q),
			.sin_x (sin_x_q),
			.cos_x (cos_x_q),
			.sin_y (sin_y_q),
			.cos_y (cos_y_q),
			.sin_z (sin_z_q),
			.cos_z (cos_z_q),
			.hf_x  (hf_x_q),
			.hf_y  (hf_y_q),
			.px    (lane_px[l]),
			.py    (lane_py[l]),
			.zero  (lane_zero[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= '{vis:   (v0_z > cam_x_q) || (v1_z > cam_x_q) || (v2_z > cam_x_q),
		               red:   red,
		               green: green,
		               blue:  blue};
		for (int k = 1; k < LAT - 1; k++)
			side_q[k] <= side_q[k-1];
		p0_x       <= lane_px[0];
		p0_y       <= lane_py[0];
		p1_x       <= lane_px[1];
		p1_y       <= lane_py[1];
		p2_x       <= lane_px[2];
		p2_y       <= lane_py[2];
		red_out    <= side_q[LAT-2].red;
		green_out  <= side_q[LAT-2].green;
		blue_out   <= side_q[LAT-2].blue;
		visible    <= side_q[LAT-2].vis;
		depth_zero <= |lane_zero;
	end

	assign done = vld_q[LAT-1];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(LAT) done)
		else $error("result beat missing after accepted triangle");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result beat without a matching triangle");

	a_zero_coords: assert property (@(posedge clk) disable iff (!arst_n)
		(done && depth_zero) |-> ((p0_x == 16'sd0 && p0_y == 16'sd0) ||
		                          (p1_x == 16'sd0 && p1_y == 16'sd0) ||
		                          (p2_x == 16'sd0 && p2_y == 16'sd0)))
		else $error("zero depth flagged without zeroed vertex");

endmodule

// ===== bench/tb.sv =====
// Testbench for triangle_rotate_project: random and directed triangles checked against a predictor.
`timescale 1ns / 100ps

module tb;

	localparam int HALF_W_PX = trp_pkg::SCREEN_WIDTH_DEF / 2;
	localparam int HALF_H_PX = trp_pkg::SCREEN_HEIGHT_DEF / 2;
	localparam int SINE_D    = trp_pkg::SINE_DEPTH_DEF;
	localparam longint COORD_MAX = 64'sd17179869183;

	typedef struct {
		logic signed [31:0] vc[9];
		logic [7:0]         r, g, b;
	} triangle_t;

	typedef struct {
		logic signed [15:0] p[6];
		logic [7:0]         r, g, b;
		logic               vis, dz;
	} screen_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic signed [31:0] vin[9];
	logic [7:0] red = '0, green = '0, blue = '0;
	logic done;
	logic signed [15:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y;
	logic [7:0] red_out, green_out, blue_out;
	logic visible, depth_zero;

	triangle_t frame_q[$];
	screen_t screen_q[$];
	triangle_t drv_tri;
	int sine_tab[0:SINE_D];
	logic signed [31:0] m_cam[3];
	logic [15:0] m_ang[3];
	logic [15:0] m_focal;
	int errors = 0;
	int beats = 0;
	int results = 0;
	int zero_hits = 0;

	initial begin
		foreach (vin[k])
			vin[k] = '0;
	end

	always #6 clk = ~clk;

	triangle_rotate_project u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.v0_x(vin[0]), .v0_y(vin[1]), .v0_z(vin[2]),
		.v1_x(vin[3]), .v1_y(vin[4]), .v1_z(vin[5]),
		.v2_x(vin[6]), .v2_y(vin[7]), .v2_z(vin[8]),
		.red(red), .green(green), .blue(blue),
		.done(done),
		.p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y), .p2_x(p2_x), .p2_y(p2_y),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.visible(visible), .depth_zero(depth_zero)
	);

	function automatic int sine_entry(int i);
		longint unsigned x, x2, term;
		longint acc;
		x    = (trp_pkg::HALF_PI_Q30 * longint'(i)) / SINE_D;
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				acc -= longint'(term);
			else
				acc += longint'(term);
		end
		if (acc < 0)
			acc = 0;
		acc = (acc + 16384) >>> 15;
		return (acc > 32767) ? 32767 : int'(acc);
	endfunction

	function automatic int sine_of(logic [15:0] a);
		int idx, v;
		idx = (int'(a[13:0]) * SINE_D) >> 14;
		v = a[14] ? sine_tab[SINE_D - idx] : sine_tab[idx];
		return a[15] ? -v : v;
	endfunction

	function automatic longint rot(longint a, longint b);
		longint t;
		t = (a + b) >>> 15;
		if (t > COORD_MAX)
			t = COORD_MAX;
		else if (t < -COORD_MAX)
			t = -COORD_MAX;
		return t;
	endfunction

	function automatic logic signed [15:0] perspective(longint half, longint num, longint depth);
		longint q;
		q = (half * longint'(m_focal) * num + half * 256 * depth) / (256 * depth);
		if (q > 32767)
			q = 32767;
		else if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	function automatic screen_t project_triangle(triangle_t t);
		screen_t s;
		longint sx, cx, sy, cy, sz, cz;
		longint x, y, z, x1, y1, x2, z2, y3, z3;
		sx = sine_of(m_ang[0]);
		cx = sine_of(m_ang[0] + 16'h4000);
		sy = sine_of(m_ang[1]);
		cy = sine_of(m_ang[1] + 16'h4000);
		sz = sine_of(m_ang[2]);
		cz = sine_of(m_ang[2] + 16'h4000);
		s.vis = 1'b0;
		s.dz = 1'b0;
		for (int k = 0; k < 3; k++) begin
			x = longint'(t.vc[3*k]) - longint'(m_cam[0]);
			y = longint'(t.vc[3*k+1]) - longint'(m_cam[1]);
			z = longint'(t.vc[3*k+2]) - longint'(m_cam[2]);
			x1 = rot(cz * x, sz * y);
			y1 = rot(cz * y, -sz * x);
			x2 = rot(cy * x1, -sy * z);
			z2 = rot(sy * x1, cy * z);
			y3 = rot(cx * y1, sx * z2);
			z3 = rot(cx * z2, -sx * y1);
			if (x2 == 0) begin
				s.p[2*k] = '0;
				s.p[2*k+1] = '0;
				s.dz = 1'b1;
			end else begin
				s.p[2*k] = perspective(HALF_W_PX, z3, x2);
				s.p[2*k+1] = perspective(HALF_H_PX, y3, x2);
			end
			if (t.vc[3*k+2] > m_cam[0])
				s.vis = 1'b1;
		end
		s.r = t.r;
		s.g = t.g;
		s.b = t.b;
		return s;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch on %s at result %0d: got %0d, want %0d", field, results, got, want);
		errors++;
	endtask

	task automatic queue_frame(triangle_t t);
		frame_q.insert(frame_q.size(), t);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				screen_q.insert(screen_q.size(), project_triangle(drv_tri));
				beats++;
			end
			if (!start || !busy) begin
				if (frame_q.size() > 0 &&
						!(!(beats >= 300 && beats < 550) && $urandom_range(0, 99) < 12)) begin
					drv_tri = frame_q.pop_front();
					foreach (vin[k])
						vin[k] <= drv_tri.vc[k];
					red <= drv_tri.r;
					green <= drv_tri.g;
					blue <= drv_tri.b;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		screen_t w;
		logic signed [15:0] got_p[6];
		if (arst_n && done) begin
			results++;
			if (screen_q.size() == 0) begin
				$display("result beat with nothing outstanding");
				errors++;
			end else begin
				w = screen_q.pop_front();
				got_p = '{p0_x, p0_y, p1_x, p1_y, p2_x, p2_y};
				for (int k = 0; k < 6; k++)
					if (got_p[k] !== w.p[k])
						report_mismatch($sformatf("p%0d_%s", k / 2, (k % 2) ? "y" : "x"),
							got_p[k], w.p[k]);
				if (red_out !== w.r)
					report_mismatch("red_out", red_out, w.r);
				if (green_out !== w.g)
					report_mismatch("green_out", green_out, w.g);
				if (blue_out !== w.b)
					report_mismatch("blue_out", blue_out, w.b);
				if (visible !== w.vis)
					report_mismatch("visible", visible, w.vis);
				if (depth_zero !== w.dz)
					report_mismatch("depth_zero", depth_zero, w.dz);
				if (w.dz)
					zero_hits++;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			trp_pkg::REG_CAM_X:   m_cam[0] = val;
			trp_pkg::REG_CAM_Y:   m_cam[1] = val;
			trp_pkg::REG_CAM_Z:   m_cam[2] = val;
			trp_pkg::REG_ANGLE_X: m_ang[0] = val[15:0];
			trp_pkg::REG_ANGLE_Y: m_ang[1] = val[15:0];
			trp_pkg::REG_ANGLE_Z: m_ang[2] = val[15:0];
			trp_pkg::REG_FOCAL:   m_focal = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [15:0] ax, logic [15:0] ay, logic [15:0] az, logic [15:0] f);
		write_reg(trp_pkg::REG_CAM_X, cx);
		write_reg(trp_pkg::REG_CAM_Y, cy);
		write_reg(trp_pkg::REG_CAM_Z, cz);
		write_reg(trp_pkg::REG_ANGLE_X, {16'd0, ax});
		write_reg(trp_pkg::REG_ANGLE_Y, {16'd0, ay});
		write_reg(trp_pkg::REG_ANGLE_Z, {16'd0, az});
		write_reg(trp_pkg::REG_FOCAL, {16'd0, f});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (frame_q.size() != 0 || start || screen_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic triangle_t random_triangle();
		triangle_t t;
		int mode;
		for (int k = 0; k < 3; k++) begin
			mode = $urandom_range(0, 99);
			for (int c = 0; c < 3; c++) begin
				if (mode < 60)
					t.vc[3*k+c] = m_cam[c] + $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000;
				else if (mode < 88)
					t.vc[3*k+c] = $urandom;
				else
					t.vc[3*k+c] = m_cam[c];
			end
		end
		t.r = 8'($urandom);
		t.g = 8'($urandom);
		t.b = 8'($urandom);
		return t;
	endfunction

	function automatic triangle_t fill_triangle(logic signed [31:0] val, logic [7:0] col);
		triangle_t t;
		foreach (t.vc[k])
			t.vc[k] = val;
		t.r = col;
		t.g = ~col;
		t.b = col;
		return t;
	endfunction

	initial begin
		triangle_t t;
		for (int i = 0; i <= SINE_D; i++)
			sine_tab[i] = sine_entry(i);
		m_cam = '{default: '0};
		m_ang = '{default: '0};
		m_focal = trp_pkg::FOCAL_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_frame(fill_triangle(32'sh0, 8'h00));
		queue_frame(fill_triangle(32'sh7FFFFFFF, 8'hFF));
		queue_frame(fill_triangle(-32'sh80000000, 8'hA5));
		queue_frame(fill_triangle(-32'sh1, 8'h5A));
		queue_frame(fill_triangle(32'sh10000, 8'h0F));
		t = fill_triangle(32'sh0, 8'hF0);
		t.vc[0] = 32'sh7FFFFFFF;
		t.vc[3] = -32'sh80000000;
		t.vc[6] = 32'sh10000;
		t.vc[7] = 32'sh7FFFFFFF;
		t.vc[8] = -32'sh80000000;
		queue_frame(t);
		t.vc[0] = 32'sh1;
		t.vc[2] = -32'sh80000000;
		t.vc[5] = 32'sh1;
		queue_frame(t);
		for (int i = 0; i < 10; i++)
			queue_frame(random_triangle());
		drain();

		set_camera(32'sh80000000, 32'sh7FFFFFFF, 32'sh0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_frame(fill_triangle(32'sh0, 8'h33));
		queue_frame(fill_triangle(-32'sh80000000, 8'hCC));
		drain();
		set_camera(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 16'h4000, 16'h8000, 16'hC000,
			16'h0);
		queue_frame(fill_triangle(32'sh7FFFFFFF, 8'h11));
		queue_frame(fill_triangle(32'sh0, 8'hEE));
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 0)
				set_camera('0, '0, '0, '0, '0, '0, trp_pkg::FOCAL_RESET);
			else
				set_camera(32'($urandom), 32'($urandom), 32'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), (ph == 5) ? 16'hFFFF : 16'($urandom));
			for (int i = 0; i < 150; i++)
				queue_frame(random_triangle());
			drain();
		end
		repeat (trp_pkg::TRP_LAT + 8) @(posedge clk);

		$display("covered %0d triangles over 9 camera settings, %0d with a zero depth vertex",
			beats, zero_hits);
		if (errors == 0 && screen_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
